// ----- rtl/core/periodic_shifted_lagrange_interp_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef PERIODIC_SHIFTED_LAGRANGE_INTERP_TOP_ASSERT_SVH
`define PERIODIC_SHIFTED_LAGRANGE_INTERP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PSLI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define PSLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/psli_pkg.sv -----
`default_nettype none
package psli_pkg;

	localparam int ROWS        = 64;
	localparam int COLUMNS     = 256;
	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 28;

	// fraction of the shift is carried as Q0.16
	localparam int UB    = 16;
	localparam int WW    = WEIGHT_BITS + 2;
	localparam int AW    = $clog2(ROWS * COLUMNS);
	localparam int PW    = $clog2(COLUMNS + 1);
	localparam int COLW  = $clog2(COLUMNS);
	localparam int IP_W  = 32 - FRAC_BITS;
	localparam int XW    = ((IP_W > 8) ? IP_W : 9) + 1;
	localparam int MW    = XW - 1;
	localparam int MS    = (MW + 3) / 4;
	localparam int MAGW  = 4 * MS;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_INTERP_ORDER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_PERIOD     = 1'b1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_INTERP = 1'b1;

	localparam logic [2:0] ORDER_LINEAR = 3'd2;
	localparam logic [2:0] ORDER_THREE  = 3'd3;
	localparam logic [2:0] ORDER_FOUR   = 3'd4;

	typedef struct packed {
		logic               operation;
		logic [5:0]         row_index;
		logic [7:0]         column_index;
		logic signed [31:0] sample_value;
		logic signed [31:0] column_shift;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic               saturated;
	} out_item_t;

	// item context carried down the pipe
	typedef struct packed {
		logic        op;
		logic [5:0]  row;
		logic [7:0]  col;
		logic [31:0] sample;
		logic        neg;
		logic        row_ok;
		logic        wr_ok;
	} ctx_t;

	// stage advance enables for the weight pipe
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} wen_t;

	typedef logic [3:0][WW-1:0] wvec_t;

endpackage
`default_nettype wire

// ----- rtl/core/psli_ram.sv -----
`default_nettype none
module psli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/psli_weights.sv -----
`default_nettype none
module psli_weights (
	input  wire logic             clk,
	input  wire psli_pkg::wen_t   en,
	input  wire logic [15:0]      t_s1,
	input  wire logic [2:0]       order,
	output psli_pkg::wvec_t       w_s6
);

	localparam int WW     = psli_pkg::WW;
	localparam int W3_SH  = 2 * psli_pkg::UB + 1 - psli_pkg::WEIGHT_BITS;
	localparam int W4_SH  = 3 * psli_pkg::UB - psli_pkg::WEIGHT_BITS;
	localparam int WL_SH  = psli_pkg::WEIGHT_BITS - psli_pkg::UB;

	localparam logic signed [17:0] U_S   = 18'sd65536;
	localparam logic signed [35:0] USQ   = 36'sh1_0000_0000;
	localparam logic signed [35:0] RND3  = 36'sd1 <<< (W3_SH - 1);
	localparam logic signed [55:0] RND4  = 56'sd3 <<< W4_SH;
	localparam logic signed [32:0] MAGIC = 33'sh0_5555_5556;

	localparam logic [2:0] ORDER_LINEAR_C = psli_pkg::ORDER_LINEAR;
	localparam logic [2:0] ORDER_THREE_C  = psli_pkg::ORDER_THREE;
	localparam logic [2:0] ORDER_FOUR_C   = psli_pkg::ORDER_FOUR;

	logic signed [17:0] ts_c;
	assign ts_c = $signed({2'b00, t_s1});

	// stage 2: first products
	logic [15:0]        t_s2;
	logic signed [17:0] b_s2;
	logic signed [35:0] p1_s2, t2_s2, p2_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			t_s2  <= t_s1;
			b_s2  <= ts_c - (U_S <<< 1);
			p1_s2 <= ts_c * (ts_c - U_S);
			t2_s2 <= ts_c * ts_c;
			p2_s2 <= ts_c * (ts_c + U_S);
		end
	end

	// stage 3: three-point weights, four-point numerators
	logic [15:0]        t_s3;
	logic [2:0][WW-1:0] w3_s3;
	logic signed [53:0] m_s3 [4];
	logic signed [35:0] d_c;
	logic signed [17:0] ts2_c;

	assign d_c   = t2_s2 - USQ;
	assign ts2_c = $signed({2'b00, t_s2});

	always_ff @(posedge clk) begin
		if (en.s3) begin
			t_s3     <= t_s2;
			w3_s3[0] <= WW'((p1_s2 + RND3) >>> W3_SH);
			w3_s3[1] <= WW'((((USQ - t2_s2) <<< 1) + RND3) >>> W3_SH);
			w3_s3[2] <= WW'((p2_s2 + RND3) >>> W3_SH);
			m_s3[0]  <= p1_s2 * b_s2;
			m_s3[1]  <= d_c * b_s2;
			m_s3[2]  <= p2_s2 * b_s2;
			m_s3[3]  <= ts2_c * d_c;
		end
	end

	// stage 4: round over 2^W4_SH and halve, leaving a divide by three
	logic [15:0]        t_s4;
	logic [2:0][WW-1:0] w3_s4;
	logic signed [31:0] z_s4 [4];
	logic signed [55:0] x_c  [4];

	always_comb begin
		x_c[0] = -56'(m_s3[0]);
		x_c[1] = 56'(m_s3[1]) + (56'(m_s3[1]) <<< 1);
		x_c[2] = -(56'(m_s3[2]) + (56'(m_s3[2]) <<< 1));
		x_c[3] = 56'(m_s3[3]);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			t_s4  <= t_s3;
			w3_s4 <= w3_s3;
			for (int i = 0; i < 4; i++) begin
				z_s4[i] <= 32'((x_c[i] + RND4) >>> (W4_SH + 1));
			end
		end
	end

	// stage 5: reciprocal multiply
	logic [15:0]        t_s5;
	logic [2:0][WW-1:0] w3_s5;
	logic signed [31:0] z_s5 [4];
	logic signed [64:0] q_s5 [4];

	always_ff @(posedge clk) begin
		if (en.s5) begin
			t_s5  <= t_s4;
			w3_s5 <= w3_s4;
			for (int i = 0; i < 4; i++) begin
				z_s5[i] <= z_s4[i];
				q_s5[i] <= z_s4[i] * MAGIC;
			end
		end
	end

	// stage 6: correct quotient, select weights by order
	logic signed [31:0] q0_c [4];
	logic signed [34:0] r_c  [4];
	logic [WW-1:0]      w4_c [4];
	psli_pkg::wvec_t    w_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			q0_c[i] = 32'(q_s5[i] >>> 32);
			r_c[i]  = 35'(z_s5[i]) - (35'(q0_c[i]) + (35'(q0_c[i]) <<< 1));
			if (r_c[i] < 0) begin
				w4_c[i] = WW'(q0_c[i] - 32'sd1);
			end else if (r_c[i] >= 35'sd3) begin
				w4_c[i] = WW'(q0_c[i] + 32'sd1);
			end else begin
				w4_c[i] = WW'(q0_c[i]);
			end
		end
		case (order)
			ORDER_LINEAR_C: begin
				w_c[0] = '0;
				w_c[1] = WW'((32'd65536 - 32'(t_s5)) << WL_SH);
				w_c[2] = WW'(32'(t_s5) << WL_SH);
				w_c[3] = '0;
			end
			ORDER_THREE_C: begin
				w_c[0] = w3_s5[0];
				w_c[1] = w3_s5[1];
				w_c[2] = w3_s5[2];
				w_c[3] = '0;
			end
			ORDER_FOUR_C: begin
				w_c[0] = w4_c[0];
				w_c[1] = w4_c[1];
				w_c[2] = w4_c[2];
				w_c[3] = w4_c[3];
			end
			default: begin
				w_c[0] = '0;
				w_c[1] = WW'(32'd1 << psli_pkg::WEIGHT_BITS);
				w_c[2] = '0;
				w_c[3] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			w_s6 <= w_c;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/periodic_shifted_lagrange_interp_top.sv -----
// Periodic column-shift interpolator over a 64 x 256 slice of Q16.16 samples.
// Input channel in_valid/in_stall/in_data: operation 0 writes sample_value at
// (row_index, column_index); operation 1 interpolates in row_index around
// column_index shifted by column_shift, wrapped modulo z_period, using the
// nearest, linear, three-point or four-point rule picked by interp_order.
// Output channel out_valid/out_stall/out_data carries one result per
// interpolate, none per write; a transfer happens when valid is high and stall
// is low. Configuration: cfg_we writes cfg_data into register cfg_index
// (0 interp_order, 1 z_period); write only while the block is idle.
// Throughput: one item per cycle while no stall holds the pipe. The pipe depth
// comes from the pipelined wrap remainder (four stages), the weight multiplier
// chain and the registered sample memory read. Four neighbours come from two
// copies of the sample memory, two read ports each, written together. Stalls:
// stages hold while the next stage is full and held, so bubbles close up and a
// stalled result does not block intake until the pipe is full. Reset clears
// valid bits and config (order 0, period 256); the sample memory is not cleared
// and needs no clearing pass.
`default_nettype none
module periodic_shifted_lagrange_interp_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire psli_pkg::in_item_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output psli_pkg::out_item_t                      out_data,
	input  wire logic                                cfg_we,
	input  wire logic [psli_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [psli_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PW    = psli_pkg::PW;
	localparam int PW1   = PW + 1;
	localparam int AW    = psli_pkg::AW;
	localparam int XW    = psli_pkg::XW;
	localparam int MW    = psli_pkg::MW;
	localparam int MS    = psli_pkg::MS;
	localparam int MAGW  = psli_pkg::MAGW;
	localparam int WW    = psli_pkg::WW;
	localparam int WB    = psli_pkg::WEIGHT_BITS;
	localparam int PRODW = WW + 32;
	localparam int ACCW  = PRODW + 2;
	localparam int FB    = psli_pkg::FRAC_BITS;
	localparam int FD_R  = (FB >= 16) ? FB - 16 : 0;
	localparam int FD_L  = (FB < 16) ? 16 - FB : 0;
	localparam logic [31:0] FRAC_MASK = (32'd1 << FB) - 32'd1;

	// configuration registers
	logic [2:0] interp_order_q;
	logic [8:0] z_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_order_q <= 3'd0;
			z_period_q     <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psli_pkg::CFG_INTERP_ORDER: interp_order_q <= cfg_data[2:0];
				psli_pkg::CFG_Z_PERIOD:     z_period_q     <= cfg_data[8:0];
			endcase
		end
	end

	// effective period: zero acts as one, clip to the column count
	logic [PW-1:0] p_c;
	always_comb begin
		if (z_period_q == 9'd0) begin
			p_c = PW'(1);
		end else if (32'(z_period_q) > psli_pkg::COLUMNS) begin
			p_c = PW'(psli_pkg::COLUMNS);
		end else begin
			p_c = PW'(z_period_q);
		end
	end

	// stage valids and advance enables; adv[10] is the output register
	logic [9:1]  vld_s;
	logic [10:1] adv;

	always_comb begin
		adv[10] = !out_valid || !out_stall;
		for (int k = 9; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[1];

	// stage 1: split the shift, form the signed column sum and its magnitude
	logic signed [XW-1:0] x_c;
	logic [31:0]          frac_c;
	logic [15:0]          u_c;
	psli_pkg::ctx_t       ctx_c;

	always_comb begin
		x_c    = XW'($signed(in_data.column_shift[31:FB])) + XW'(in_data.column_index);
		frac_c = 32'(in_data.column_shift) & FRAC_MASK;
		u_c    = 16'((frac_c >> FD_R) << FD_L);
		ctx_c.op     = in_data.operation;
		ctx_c.row    = in_data.row_index;
		ctx_c.col    = in_data.column_index;
		ctx_c.sample = in_data.sample_value;
		ctx_c.neg    = x_c[XW-1];
		ctx_c.row_ok = 32'(in_data.row_index) < psli_pkg::ROWS;
		ctx_c.wr_ok  = (32'(in_data.row_index) < psli_pkg::ROWS)
			&& (32'(in_data.column_index) < psli_pkg::COLUMNS);
	end

	psli_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	logic [MAGW-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [15:0]     u_s1;
	logic [PW-1:0]   rem_s2, rem_s3, rem_s4, rem_s5;
	logic [PW-1:0]   base_s6;

	// MS restoring remainder steps, MSB first
	function automatic logic [PW-1:0] mod_step(input logic [PW-1:0] r_in,
		input logic [MS-1:0] bits, input logic [PW-1:0] p);
		logic [PW:0] acc;
		acc = {1'b0, r_in};
		for (int i = MS - 1; i >= 0; i--) begin
			acc = {acc[PW-1:0], bits[i]};
			if (acc >= {1'b0, p}) begin
				acc = acc - {1'b0, p};
			end
		end
		return acc[PW-1:0];
	endfunction

	logic [MW-1:0] mag_c;
	assign mag_c = x_c[XW-1] ? MW'(-x_c) : MW'(x_c);

	logic [PW-1:0] base_c;
	assign base_c = (ctx_s5.neg && rem_s5 != '0) ? p_c - rem_s5 : rem_s5;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ctx_s1 <= ctx_c;
			mag_s1 <= MAGW'(mag_c);
			u_s1   <= u_c;
		end
		if (adv[2]) begin
			ctx_s2 <= ctx_s1;
			mag_s2 <= mag_s1;
			rem_s2 <= mod_step('0, mag_s1[MAGW-1 -: MS], p_c);
		end
		if (adv[3]) begin
			ctx_s3 <= ctx_s2;
			mag_s3 <= mag_s2;
			rem_s3 <= mod_step(rem_s2, mag_s2[MAGW-1-MS -: MS], p_c);
		end
		if (adv[4]) begin
			ctx_s4 <= ctx_s3;
			mag_s4 <= mag_s3;
			rem_s4 <= mod_step(rem_s3, mag_s3[MAGW-1-2*MS -: MS], p_c);
		end
		if (adv[5]) begin
			ctx_s5 <= ctx_s4;
			rem_s5 <= mod_step(rem_s4, mag_s4[MS-1:0], p_c);
		end
		if (adv[6]) begin
			ctx_s6  <= ctx_s5;
			base_s6 <= base_c;
		end
	end

	// weights run beside the remainder, ready at stage 6
	psli_pkg::wen_t  wen;
	psli_pkg::wvec_t w_s6;

	assign wen.s2 = adv[2];
	assign wen.s3 = adv[3];
	assign wen.s4 = adv[4];
	assign wen.s5 = adv[5];
	assign wen.s6 = adv[6];

	psli_weights u_weights (
		.clk   (clk),
		.en    (wen),
		.t_s1  (u_s1),
		.order (interp_order_q),
		.w_s6  (w_s6)
	);

	// stage 6 -> 7: wrap neighbour columns, issue reads and the write
	logic [PW1-1:0] bx_c, px_c, cm1_c, cp1_c, cp2_c;
	logic [AW-1:0]  ra0_c, ra1_c, ra2_c, ra3_c, wa_c;
	logic           we_c;

	function automatic logic [AW-1:0] addr_of(input logic [5:0] row,
		input logic [PW1-1:0] col);
		return AW'(32'(row) * psli_pkg::COLUMNS + 32'(col));
	endfunction

	always_comb begin
		bx_c  = PW1'(base_s6);
		px_c  = PW1'(p_c);
		cm1_c = (bx_c == '0) ? px_c - PW1'(1) : bx_c - PW1'(1);
		cp1_c = bx_c + PW1'(1);
		if (cp1_c >= px_c) begin
			cp1_c = cp1_c - px_c;
		end
		cp2_c = bx_c + PW1'(2);
		if (cp2_c >= px_c) begin
			cp2_c = cp2_c - px_c;
		end
		// a period of one needs a second wrap
		if (cp2_c >= px_c) begin
			cp2_c = cp2_c - px_c;
		end
		ra0_c = addr_of(ctx_s6.row, cm1_c);
		ra1_c = addr_of(ctx_s6.row, bx_c);
		ra2_c = addr_of(ctx_s6.row, cp1_c);
		ra3_c = addr_of(ctx_s6.row, cp2_c);
		wa_c  = addr_of(ctx_s6.row, PW1'(ctx_s6.col));
		we_c  = vld_s[6] && adv[7] && (ctx_s6.op == psli_pkg::OP_WRITE) && ctx_s6.wr_ok;
	end

	logic [31:0] smp0_s7, smp1_s7, smp2_s7, smp3_s7;

	psli_ram #(.WIDTH(32), .DEPTH(psli_pkg::ROWS * psli_pkg::COLUMNS)) u_ram_lo (
		.clk     (clk),
		.we      (we_c),
		.waddr   (wa_c),
		.wdata   (ctx_s6.sample),
		.re      (adv[7]),
		.raddr_a (ra0_c),
		.raddr_b (ra1_c),
		.rdata_a (smp0_s7),
		.rdata_b (smp1_s7)
	);

	psli_ram #(.WIDTH(32), .DEPTH(psli_pkg::ROWS * psli_pkg::COLUMNS)) u_ram_hi (
		.clk     (clk),
		.we      (we_c),
		.waddr   (wa_c),
		.wdata   (ctx_s6.sample),
		.re      (adv[7]),
		.raddr_a (ra2_c),
		.raddr_b (ra3_c),
		.rdata_a (smp2_s7),
		.rdata_b (smp3_s7)
	);

	logic            row_ok_s7;
	psli_pkg::wvec_t w_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			row_ok_s7 <= ctx_s6.row_ok;
			w_s7      <= w_s6;
		end
	end

	// stage 7 -> 8: weight times sample; a row out of range reads zeros
	logic signed [31:0]      s_c [4];
	logic signed [PRODW-1:0] prod_s8 [4];

	always_comb begin
		s_c[0] = row_ok_s7 ? $signed(smp0_s7) : 32'sd0;
		s_c[1] = row_ok_s7 ? $signed(smp1_s7) : 32'sd0;
		s_c[2] = row_ok_s7 ? $signed(smp2_s7) : 32'sd0;
		s_c[3] = row_ok_s7 ? $signed(smp3_s7) : 32'sd0;
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			for (int i = 0; i < 4; i++) begin
				prod_s8[i] <= $signed(w_s7[i]) * s_c[i];
			end
		end
	end

	// stage 9: accumulate
	logic signed [ACCW-1:0] acc_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			acc_s9 <= ACCW'(prod_s8[0]) + ACCW'(prod_s8[1])
				+ ACCW'(prod_s8[2]) + ACCW'(prod_s8[3]);
		end
	end

	// output: round to nearest, clip to 32 bits
	logic signed [ACCW-1:0] rnd_c;
	logic                   sat_hi_c, sat_lo_c;
	psli_pkg::out_item_t    res_c, out_data_q;

	always_comb begin
		rnd_c    = (acc_s9 + (ACCW'(1) <<< (WB - 1))) >>> WB;
		sat_hi_c = !rnd_c[ACCW-1] && (|rnd_c[ACCW-2:31]);
		sat_lo_c = rnd_c[ACCW-1] && !(&rnd_c[ACCW-2:31]);
		res_c.saturated = sat_hi_c || sat_lo_c;
		if (sat_hi_c) begin
			res_c.interp_value = 32'sh7fff_ffff;
		end else if (sat_lo_c) begin
			res_c.interp_value = 32'sh8000_0000;
		end else begin
			res_c.interp_value = rnd_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			out_data_q <= res_c;
		end
	end

	assign out_data = out_data_q;

	// valid bits; writes drop out after the memory stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv[1]) vld_s[1] <= in_valid;
			for (int k = 2; k <= 9; k++) begin
				if (adv[k]) begin
					if (k == 7) begin
						vld_s[k] <= vld_s[6] && (ctx_s6.op == psli_pkg::OP_INTERP);
					end else begin
						vld_s[k] <= vld_s[k-1];
					end
				end
			end
			if (adv[10]) out_valid <= vld_s[9];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/psli_checker.sv -----
`default_nettype none
`include "periodic_shifted_lagrange_interp_top_assert.svh"
module psli_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire psli_pkg::out_item_t out_data
);

	// a stalled result stays and holds its value
	`PSLI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// a clipped result sits on a rail
	`PSLI_ASSERT_NOW(a_sat_rail, out_valid && out_data.saturated, (out_data.interp_value == 32'sh7fff_ffff) || (out_data.interp_value == 32'sh8000_0000), "saturated off rail")

	// intake stops only behind a held result
	`PSLI_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

endmodule

bind periodic_shifted_lagrange_interp_top psli_checker u_psli_checker (.*);
`default_nettype wire

// ----- tb/sv/periodic_shifted_lagrange_interp_top_tb.sv -----
`default_nettype none
module periodic_shifted_lagrange_interp_top_tb;
	import psli_pkg::*;

	// Directed stimulus row: expectation is typed in only where obvious.
	typedef struct {
		logic        op;
		logic [5:0]  row;
		logic [7:0]  col;
		logic [31:0] sample;
		logic [31:0] shift;
		bit          typed;
		logic [31:0] val;
		logic        sat;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_INTERP_ORDER;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model of the sample store and registers, as applied at each transfer
	logic signed [31:0] slice_mem [ROWS][COLUMNS];
	bit          filled [ROWS][COLUMNS];   // columns scheduled for a write
	logic [2:0]  cur_order = 3'd0;
	logic [8:0]  cur_period = 9'd256;
	out_item_t   pending_q [$];
	int          errs = 0;

	// Side channel for the item on the bus: typed expectation if any
	bit          cur_typed = 1'b0;
	out_item_t   cur_exp;

	// Stall control for the result side, gap control for the sender
	bit          rx_idle_on = 1'b1;
	bit          hold_req = 1'b0;
	bit          tx_idle_on = 1'b1;

	dir_row_t    dir_tab [$];

	periodic_shifted_lagrange_interp_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint fdiv(longint x, longint d);
		longint q;
		q = x / d;
		if ((x % d) != 0 && x < 0)
			q--;
		return q;
	endfunction

	function automatic longint fmod(longint x, longint d);
		return x - fdiv(x, d) * d;
	endfunction

	function automatic longint eff_period();
		longint p;
		p = longint'(cur_period);
		if (p < 1)
			p = 1;
		if (p > COLUMNS)
			p = COLUMNS;
		return p;
	endfunction

	// Column of neighbour k (0..3 = base-1..base+2) after shift and wrap
	function automatic int neighbour_col(logic [7:0] col, logic signed [31:0] shift, int k);
		longint p, base;
		p = eff_period();
		base = fmod(longint'(col) + fdiv(longint'(shift), 65536), p);
		return int'(fmod(base + k - 1, p));
	endfunction

	function automatic out_item_t interp_predict(logic [5:0] row, logic [7:0] col,
			logic signed [31:0] shift);
		longint t, acc, res;
		longint w [4];
		longint s [4];
		longint big_u;
		longint den6;
		out_item_t r;
		big_u = 65536;
		den6 = 6 * (longint'(1) << 20);
		t = longint'(shift[15:0]);
		for (int k = 0; k < 4; k++)
			s[k] = longint'(slice_mem[row][neighbour_col(col, shift, k)]);
		case (cur_order)
			ORDER_LINEAR: begin
				w[0] = 0;
				w[1] = (big_u - t) << 12;
				w[2] = t << 12;
				w[3] = 0;
			end
			ORDER_THREE: begin
				w[0] = fdiv(t * (t - big_u) + 16, 32);
				w[1] = fdiv(2 * (big_u * big_u - t * t) + 16, 32);
				w[2] = fdiv(t * (t + big_u) + 16, 32);
				w[3] = 0;
			end
			ORDER_FOUR: begin
				w[0] = fdiv(-t * (t - big_u) * (t - 2 * big_u) + den6 / 2, den6);
				w[1] = fdiv(3 * (t * t - big_u * big_u) * (t - 2 * big_u) + den6 / 2, den6);
				w[2] = fdiv(-3 * t * (t + big_u) * (t - 2 * big_u) + den6 / 2, den6);
				w[3] = fdiv(t * (t * t - big_u * big_u) + den6 / 2, den6);
			end
			default: begin
				w[0] = 0;
				w[1] = longint'(1) << 28;
				w[2] = 0;
				w[3] = 0;
			end
		endcase
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += w[k] * s[k];
		res = fdiv(acc + (longint'(1) << 27), longint'(1) << 28);
		r.saturated = 1'b0;
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
			r.saturated = 1'b1;
		end else if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
			r.saturated = 1'b1;
		end
		r.interp_value = res[31:0];
		return r;
	endfunction

	// Track each input transfer: update the store, queue the expected result
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			if (in_data.operation == OP_WRITE)
				slice_mem[in_data.row_index][in_data.column_index] <= in_data.sample_value;
			else if (cur_typed)
				pending_q.push_back(cur_exp);
			else
				pending_q.push_back(interp_predict(in_data.row_index,
					in_data.column_index, in_data.column_shift));
		end
	end

	// Check each output transfer against the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result value=%h sat=%b", $time,
					out_data.interp_value, out_data.saturated);
				errs++;
			end else begin
				e = pending_q.pop_front();
				if (out_data.interp_value !== e.interp_value) begin
					$display("%0t: interp_value expected %h actual %h", $time,
						e.interp_value, out_data.interp_value);
					errs++;
				end
				if (out_data.saturated !== e.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						e.saturated, out_data.saturated);
					errs++;
				end
			end
		end
	end

	// Result side: random stalls, and one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			if (!rx_idle_on)
				out_stall = 1'b0;
			else if ($urandom_range(0, 99) < 25)
				out_stall = 1'b1;
			else if ($urandom_range(0, 99) < 3) begin
				out_stall = 1'b1;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end else
				out_stall = 1'b0;
		end
	end

	// Hang guard
	initial begin
		#8000000;
		$display("Test completed with failures");
		$finish;
	end

	// Offer one item at the falling edge and hold it until a transfer
	task automatic send(in_item_t it, bit typed, out_item_t ex);
		int gap;
		in_data = it;
		cur_typed = typed;
		cur_exp = ex;
		in_valid = 1'b1;
		if (it.operation == OP_WRITE)
			filled[it.row_index][it.column_index] = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		// drop valid only when a gap follows
		gap = 0;
		if (tx_idle_on) begin
			if ($urandom_range(0, 99) < 20)
				gap = $urandom_range(1, 3);
			else if ($urandom_range(0, 99) < 2)
				gap = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic go_idle();
		in_valid = 1'b0;
		wait (pending_q.size() == 0);
		repeat (14) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_INTERP_ORDER)
			cur_order = d[2:0];
		else
			cur_period = d;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			3: return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_shift();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return {16'($signed($urandom_range(0, 8)) - 4), 16'h0};
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
		endcase
	endfunction

	// One random item: mostly interpolations, preceded by writes that fill
	// any neighbour not yet written so no read hits an unwritten entry
	task automatic rand_item();
		in_item_t it;
		out_item_t none;
		int c;
		none = '0;
		it.row_index = $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 3));
		it.column_index = $urandom;
		it.sample_value = rand_sample();
		it.column_shift = rand_shift();
		if ($urandom_range(0, 99) < 25) begin
			it.operation = OP_WRITE;
			send(it, 1'b0, none);
		end else begin
			it.operation = OP_INTERP;
			for (int k = 0; k < 4; k++) begin
				c = neighbour_col(it.column_index, it.column_shift, k);
				if (!filled[it.row_index][c])
					send('{OP_WRITE, it.row_index, 8'(c), rand_sample(), 32'($urandom)},
						1'b0, none);
			end
			send(it, 1'b0, none);
		end
	endtask

	function automatic void add_row(logic op, logic [5:0] row, logic [7:0] col,
			logic [31:0] sample, logic [31:0] shift, bit typed, logic [31:0] val);
		dir_tab.push_back('{op, row, col, sample, shift, typed, val, 1'b0});
	endfunction

	initial begin
		logic [2:0] orders [10];
		logic [8:0] periods [10];
		out_item_t  ex;
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLUMNS; c++)
				filled[r][c] = 1'b0;

		// Nearest rule after reset, period 256: the base sample comes back as is
		add_row(OP_WRITE, 6'd0, 8'd255, 32'h0000_8000, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd0, 8'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		add_row(OP_WRITE, 6'd0, 8'd1, 32'h8000_0000, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd0, 8'd2, 32'h0001_0000, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd0, 8'd3, 32'h0000_0000, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd0, 8'd4, 32'hFFFF_0000, 32'h0, 0, 0);
		add_row(OP_INTERP, 6'd0, 8'd0, 32'h0, 32'h0000_0000, 1, 32'h7FFF_FFFF);
		add_row(OP_INTERP, 6'd0, 8'd1, 32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h8000_0000);
		// largest shift lands one column back, smallest wraps onto the base
		add_row(OP_INTERP, 6'd0, 8'd1, 32'h0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF);
		add_row(OP_INTERP, 6'd0, 8'd0, 32'h0, 32'h8000_0000, 1, 32'h7FFF_FFFF);
		add_row(OP_INTERP, 6'd0, 8'd255, 32'h0, 32'h0001_0000, 1, 32'h7FFF_FFFF);
		add_row(OP_INTERP, 6'd0, 8'd2, 32'h0, 32'hFFFF_0000, 1, 32'h8000_0000);
		add_row(OP_INTERP, 6'd0, 8'd2, 32'h0, 32'h0000_8000, 0, 0);
		add_row(OP_WRITE, 6'd63, 8'd255, 32'hFFFF_FFFF, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd63, 8'd0, 32'h8000_0000, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd63, 8'd1, 32'h1234_5678, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd63, 8'd2, 32'h7FFF_FFFF, 32'h0, 0, 0);
		add_row(OP_WRITE, 6'd63, 8'd3, 32'h0000_0001, 32'h0, 0, 0);
		add_row(OP_INTERP, 6'd63, 8'd0, 32'h0, 32'h0000_FFFF, 1, 32'h8000_0000);
		add_row(OP_INTERP, 6'd63, 8'd2, 32'h0, 32'h0000_0000, 1, 32'h7FFF_FFFF);
		add_row(OP_INTERP, 6'd63, 8'd1, 32'h0, 32'hFFFF_FFFF, 0, 0);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			ex.interp_value = dir_tab[i].val;
			ex.saturated = dir_tab[i].sat;
			send('{dir_tab[i].op, dir_tab[i].row, dir_tab[i].col, dir_tab[i].sample,
				dir_tab[i].shift}, dir_tab[i].typed, ex);
		end

		// Settings per phase, extremes included: period 0 acts as 1,
		// 511 as the full width, order 5 falls back to nearest
		orders  = '{ORDER_LINEAR, ORDER_THREE, ORDER_FOUR, ORDER_FOUR, ORDER_THREE,
			ORDER_LINEAR, 3'd0, 3'd5, ORDER_FOUR, 3'd7};
		periods = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd7, 9'd2, 9'd3, 9'd256, 9'd5, 9'd100};
		for (int ph = 0; ph < 10; ph++) begin
			go_idle();
			cfg_write(CFG_INTERP_ORDER, {6'd0, orders[ph]});
			cfg_write(CFG_Z_PERIOD, periods[ph]);
			tx_idle_on = (ph % 4) != 3;
			rx_idle_on = (ph % 3) != 2;
			// fill the pipe against a long result hold-off
			if (ph == 2)
				hold_req = 1'b1;
			for (int n = 0; n < 110; n++) begin
				rand_item();
				// pause the sender until every result is back
				if (ph == 4 && n == 50) begin
					in_valid = 1'b0;
					wait (pending_q.size() == 0);
					@(negedge clk);
				end
			end
		end

		in_valid = 1'b0;
		wait (pending_q.size() == 0);
		repeat (30) @(posedge clk);
		if (errs == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
